/* hw/rtl/btrc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package btrc_pkg;

    localparam int COUNT_BITS      = 16;
    localparam int RENDER_PRIORITY = 25600;

    localparam int BUDGET_W  = 32;
    localparam int POINT_W   = 24;
    localparam int PRIO_W    = 32;
    localparam int NODE_W    = 16;
    localparam int TOTAL_W   = 16;
    localparam int CFG_IDX_W = 2;

    localparam int IN_DATA_W  = 72;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 72;

    localparam logic [CFG_IDX_W-1:0] REG_RENDER_BUDGET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GPU_BUDGET    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CPU_BUDGET    = 2'd2;

    localparam logic [1:0] TIER_RENDER = 2'd0;
    localparam logic [1:0] TIER_GPU    = 2'd1;
    localparam logic [1:0] TIER_CPU    = 2'd2;
    localparam logic [1:0] TIER_DONE   = 2'd3;

    localparam logic signed [PRIO_W-1:0] PRIO_RENDER = PRIO_W'(RENDER_PRIORITY);

endpackage

`default_nettype wire

/* hw/rtl/budget_tier_residency_classifier_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// budget tier residency classifier
// chunk descriptors arrive on the s_axis side in falling priority order, one
// transfer per chunk; each produces exactly one classification transfer on the
// m_axis side. tlast on the input marks the final chunk of a frame and comes
// back as tlast on its result; after that chunk the running point sum, tier,
// counts and budget flag return to their frame start values.
// budgets are written through the plain write port (index 0 render, 1 gpu,
// 2 cpu), by the user only while no chunk is in flight, which the block does
// not enforce; other indexes are ignored. each result is valid in the cycle
// after acceptance. throughput is one chunk per cycle while the receiver is
// ready, set by the single output register; the three budget compares of the
// tier chain sit between the accepted descriptor and that register.
// s_axis_tready is high whenever the output register is empty or is being
// drained in the same cycle, so a stalled receiver holds the result and stops
// input after one chunk.
// synchronous reset clears budgets to zero, the frame state and the output
// valid flag.
module budget_tier_residency_classifier_core (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire [btrc_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  wire [btrc_pkg::BUDGET_W-1:0]     i_cfg_wdata,
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    // point_count[23:0], priority_req[55:24], node_id[71:56]
    input  wire [btrc_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // resident[0]
    input  wire [btrc_pkg::IN_USER_W-1:0]    s_axis_tuser,
    input  wire                              s_axis_tlast,
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    // node_id_out[15:0], render_now[16], load_request[17], keep_on_gpu[18],
    // keep_on_cpu[19], render_total[35:20], hit_total[51:36],
    // miss_total[67:52], budget_low[68], zero[71:69]
    output logic [btrc_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    output logic                             m_axis_tlast
);
    import btrc_pkg::*;

    localparam int SUM_W = BUDGET_W + 1;

    logic [BUDGET_W-1:0]   r_render_budget;
    logic [BUDGET_W-1:0]   r_gpu_budget;
    logic [BUDGET_W-1:0]   r_cpu_budget;

    logic [1:0]            r_tier, n_tier;
    logic [BUDGET_W-1:0]   r_point_sum, n_point_sum;
    logic [COUNT_BITS-1:0] r_render_cnt, n_render_cnt;
    logic [COUNT_BITS-1:0] r_hit_cnt, n_hit_cnt;
    logic [COUNT_BITS-1:0] r_miss_cnt, n_miss_cnt;
    logic                  r_budget_flag, n_budget_flag;

    logic                  r_out_valid;
    logic [NODE_W-1:0]     r_node_id;
    logic                  r_render_now, r_load, r_kgpu, r_kcpu, r_budget_low, r_last;
    logic [TOTAL_W-1:0]    r_render_total, r_hit_total, r_miss_total;

    logic [POINT_W-1:0]      in_points;
    logic signed [PRIO_W-1:0] in_prio;
    logic [NODE_W-1:0]       in_node;
    logic                    in_resident;
    logic                    accept;

    logic [SUM_W-1:0] sum;
    logic prio_high, prio_pos;
    logic placed;
    logic f_render_now, f_load, f_kgpu, f_kcpu;
    logic [COUNT_BITS+TOTAL_W-1:0] ext_render, ext_hit, ext_miss;

    assign in_points   = s_axis_tdata[POINT_W-1:0];
    assign in_prio     = s_axis_tdata[POINT_W+PRIO_W-1:POINT_W];
    assign in_node     = s_axis_tdata[POINT_W+PRIO_W+NODE_W-1:POINT_W+PRIO_W];
    assign in_resident = s_axis_tuser[0];

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign sum       = {1'b0, r_point_sum} + SUM_W'(in_points);
    assign prio_high = in_prio >= PRIO_RENDER;
    assign prio_pos  = in_prio > $signed(PRIO_W'(0));

    always_comb begin
        n_tier        = r_tier;
        n_point_sum   = r_point_sum;
        n_render_cnt  = r_render_cnt;
        n_hit_cnt     = r_hit_cnt;
        n_miss_cnt    = r_miss_cnt;
        n_budget_flag = r_budget_flag;
        placed        = 1'b0;
        f_render_now  = 1'b0;
        f_load        = 1'b0;
        f_kgpu        = 1'b0;
        f_kcpu        = 1'b0;

        if (n_tier == TIER_RENDER) begin
            if (sum > {1'b0, r_render_budget}) begin
                n_budget_flag = prio_high;
                n_tier        = TIER_GPU;
            end else if (!prio_high) begin
                n_tier = TIER_GPU;
            end else begin
                if (in_resident) begin
                    f_render_now = 1'b1;
                    f_kgpu       = 1'b1;
                    f_kcpu       = 1'b1;
                    if (r_render_cnt != '1) n_render_cnt = r_render_cnt + 1'b1;
                    if (r_hit_cnt != '1) n_hit_cnt = r_hit_cnt + 1'b1;
                end else begin
                    f_load = 1'b1;
                    if (r_miss_cnt != '1) n_miss_cnt = r_miss_cnt + 1'b1;
                end
                placed = 1'b1;
            end
        end
        if (!placed && n_tier == TIER_GPU) begin
            if (sum >= {1'b0, r_gpu_budget}) begin
                n_tier = TIER_CPU;
            end else begin
                f_load = !in_resident && prio_pos;
                f_kgpu = 1'b1;
                f_kcpu = 1'b1;
                placed = 1'b1;
            end
        end
        if (!placed && n_tier == TIER_CPU) begin
            if (sum > {1'b0, r_cpu_budget}) begin
                n_tier = TIER_DONE;
            end else begin
                f_load = !in_resident && prio_pos;
                f_kcpu = 1'b1;
                placed = 1'b1;
            end
        end
        if (placed) n_point_sum = sum[BUDGET_W-1:0];
    end

    assign ext_render = {{TOTAL_W{1'b0}}, n_render_cnt};
    assign ext_hit    = {{TOTAL_W{1'b0}}, n_hit_cnt};
    assign ext_miss   = {{TOTAL_W{1'b0}}, n_miss_cnt};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_render_budget <= '0;
            r_gpu_budget    <= '0;
            r_cpu_budget    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_RENDER_BUDGET: r_render_budget <= i_cfg_wdata;
                REG_GPU_BUDGET:    r_gpu_budget    <= i_cfg_wdata;
                REG_CPU_BUDGET:    r_cpu_budget    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tier        <= TIER_RENDER;
            r_point_sum   <= '0;
            r_render_cnt  <= '0;
            r_hit_cnt     <= '0;
            r_miss_cnt    <= '0;
            r_budget_flag <= 1'b0;
        end else if (accept) begin
            if (s_axis_tlast) begin
                r_tier        <= TIER_RENDER;
                r_point_sum   <= '0;
                r_render_cnt  <= '0;
                r_hit_cnt     <= '0;
                r_miss_cnt    <= '0;
                r_budget_flag <= 1'b0;
            end else begin
                r_tier        <= n_tier;
                r_point_sum   <= n_point_sum;
                r_render_cnt  <= n_render_cnt;
                r_hit_cnt     <= n_hit_cnt;
                r_miss_cnt    <= n_miss_cnt;
                r_budget_flag <= n_budget_flag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_node_id      <= in_node;
            r_render_now   <= f_render_now;
            r_load         <= f_load;
            r_kgpu         <= f_kgpu;
            r_kcpu         <= f_kcpu;
            r_render_total <= ext_render[TOTAL_W-1:0];
            r_hit_total    <= ext_hit[TOTAL_W-1:0];
            r_miss_total   <= ext_miss[TOTAL_W-1:0];
            r_budget_low   <= n_budget_flag;
            r_last         <= s_axis_tlast;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_last;
    assign m_axis_tdata  = {3'b000, r_budget_low, r_miss_total, r_hit_total, r_render_total,
                            r_kcpu, r_kgpu, r_load, r_render_now, r_node_id};

    a_render_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_render_now |-> r_kgpu && r_kcpu && !r_load)
        else $error("rendered chunk without both keep marks");

    a_gpu_implies_cpu: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_kgpu |-> r_kcpu)
        else $error("gpu keep without cpu keep");

    a_frame_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && s_axis_tlast |=> r_tier == TIER_RENDER && r_point_sum == '0
            && r_render_cnt == '0 && !r_budget_flag)
        else $error("frame state not cleared after last chunk");

    a_tier_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !s_axis_tlast |=> r_tier >= $past(r_tier))
        else $error("tier moved backwards within a frame");

endmodule

`default_nettype wire
